@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on aclk, disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property at every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check an implication at every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// check a next-cycle consequence outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/stb_pkg.sv @@
// ---------------------------------------------------------------------------
// stb_pkg
// Types and codes shared by the sorted table cells and top level.
// ---------------------------------------------------------------------------
package stb_pkg;

    localparam int unsigned ValueWidth  = 32;
    localparam int unsigned StatusWidth = 3;
    localparam int unsigned CountWidth  = 5;

    typedef enum logic [StatusWidth-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_DELETE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                  ins_en;
        logic                  del_en;
        logic [ValueWidth-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic less;
        logic match;
    } cell_flag_t;

endpackage

@@ design/stb_cell.sv @@
// ---------------------------------------------------------------------------
// stb_cell
// One slot of the sorted table: compares its entry with the operand and
// takes the operand, its left neighbour or its right neighbour, or keeps its own.
// ---------------------------------------------------------------------------
module stb_cell (
    input  logic                                aclk,
    input  stb_pkg::cell_ctrl_t                 ctrl,
    input  logic                                occupied,
    input  logic                                left_less,
    input  logic [stb_pkg::ValueWidth-1:0]      left_entry,
    input  logic [stb_pkg::ValueWidth-1:0]      right_entry,
    output stb_pkg::cell_flag_t                 flag,
    output logic [stb_pkg::ValueWidth-1:0]      entry
);

    logic [stb_pkg::ValueWidth-1:0] entry_reg;
    logic [stb_pkg::ValueWidth-1:0] entry_next;

    assign flag.less  = occupied && ($signed(entry_reg) < $signed(ctrl.value));
    assign flag.match = occupied && (entry_reg == ctrl.value);
    assign entry      = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins_en && !flag.less) begin
            entry_next = left_less ? ctrl.value : left_entry;
        end else if (ctrl.del_en && !flag.less) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

@@ design/sorted_table_insert_delete_top.sv @@
// ---------------------------------------------------------------------------
// sorted_table_insert_delete_top
// Ascending table of signed values with insert in order and delete by value,
// built as a row of compare-and-shift cells.
// ---------------------------------------------------------------------------
//  channel | ports                            | direction
//  s_      | s_valid s_ready s_cmd s_value    | in, one operation
//  m_      | m_valid m_ready m_status         | out, one result per operation
//          | m_entry_count m_smallest         |
//
//  All cells compare against the operand together and shift in the same
//  edge, so a new operation is taken every cycle unless a held result stalls.
//  The result register frees s_ready whenever it is empty or being taken.
//  Reset clears the fill count and the result valid; cell contents are kept.
//  A stalled result holds the table unchanged until it is taken.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_table_insert_delete_top #(
    parameter int unsigned TABLE_DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_cmd,
    input  logic signed [stb_pkg::ValueWidth-1:0]  s_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [stb_pkg::StatusWidth-1:0]        m_status,
    output logic [stb_pkg::CountWidth-1:0]         m_entry_count,
    output logic signed [stb_pkg::ValueWidth-1:0]  m_smallest
);

    localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

    logic [CntW-1:0]           count_reg;
    logic [CntW-1:0]           count_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    stb_pkg::status_t          status_reg;
    stb_pkg::status_t          status_next;

    logic                      accept;
    logic                      is_full;
    logic                      is_empty;
    logic                      found;
    stb_pkg::cell_ctrl_t       ctrl;

    logic [stb_pkg::ValueWidth-1:0] entry [TABLE_DEPTH];
    stb_pkg::cell_flag_t            flag  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]         match_vec;
    logic [CntW+stb_pkg::CountWidth-1:0] count_wide;

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CntW'(TABLE_DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            match_vec[i] = flag[i].match;
        end
    end
    assign found = |match_vec;

    assign ctrl.value  = s_value;
    assign ctrl.ins_en = accept && (s_cmd == stb_pkg::CMD_INSERT) && !is_full;
    assign ctrl.del_en = accept && (s_cmd == stb_pkg::CMD_DELETE) && found;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic                           left_less;
        logic [stb_pkg::ValueWidth-1:0] left_entry;
        logic [stb_pkg::ValueWidth-1:0] right_entry;

        if (g == 0) begin : g_head
            assign left_less  = 1'b1;
            assign left_entry = entry[g];
        end else begin : g_body
            assign left_less  = flag[g-1].less;
            assign left_entry = entry[g-1];
        end

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign right_entry = entry[g];
        end else begin : g_inner
            assign right_entry = entry[g+1];
        end

        stb_cell u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .occupied    (CntW'(g) < count_reg),
            .left_less   (left_less),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .flag        (flag[g]),
            .entry       (entry[g])
        );
    end

    always_comb begin
        count_next  = count_reg;
        status_next = status_reg;
        if (accept) begin
            if (s_cmd == stb_pkg::CMD_INSERT) begin
                if (is_full) begin
                    status_next = stb_pkg::ST_FULL;
                end else begin
                    status_next = stb_pkg::ST_INSERTED;
                    count_next  = count_reg + CntW'(1);
                end
            end else if (is_empty) begin
                status_next = stb_pkg::ST_EMPTY;
            end else if (found) begin
                status_next = stb_pkg::ST_DELETED;
                count_next  = count_reg - CntW'(1);
            end else begin
                status_next = stb_pkg::ST_NOT_FOUND;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
    end

    assign count_wide    = {{stb_pkg::CountWidth{1'b0}}, count_reg};
    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_entry_count = count_wide[stb_pkg::CountWidth-1:0];
    assign m_smallest    = is_empty ? '0 : $signed(entry[0]);

    `ASSERT_CLK(a_count_bound, count_reg <= CntW'(TABLE_DEPTH), "fill count above table depth")
    `ASSERT_NEXT(a_full_hold, accept && (s_cmd == stb_pkg::CMD_INSERT) && is_full,
        count_reg == $past(count_reg), "insert into full table changed the count")
    `ASSERT_NEXT(a_result_after_accept, accept, m_valid_reg, "accepted transaction gave no result")
    `ASSERT_IMPL(a_one_edit, 1'b1, !(ctrl.ins_en && ctrl.del_en), "insert and delete together")

endmodule
